>>> sv/ikslv_pkg.sv
package ikslv_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQL,
        S_DIST,
        S_ELEV,
        S_XS,
        S_YS,
        S_HALF,
        S_ANG,
        S_FIN
    } t_state;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_X       = 3'd0;
    localparam logic [2:0] CFG_BASE_Y       = 3'd1;
    localparam logic [2:0] CFG_LINK_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_SHOULDER_MAX = 3'd3;
    localparam logic [2:0] CFG_SHOULDER_MIN = 3'd4;
    localparam logic [2:0] CFG_ELBOW_MIN    = 3'd5;

    // status codes
    localparam logic [1:0] ST_REACHABLE = 2'd0;
    localparam logic [1:0] ST_BEYOND    = 2'd1;
    localparam logic [1:0] ST_AT_BASE   = 2'd2;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam int ATAN_LEN   = 20;
    localparam int ATAN_IDX_W = 5;
    localparam int Z_W        = 33;

    // atan(2^-i) in Q30
    localparam logic [30:0] ATAN_Q30 [ATAN_LEN] = '{
        31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
        31'd33543515,  31'd16775850,  31'd8388437,   31'd4194282,   31'd2097149,
        31'd1048575,   31'd524287,    31'd262143,    31'd131071,    31'd65535,
        31'd32767,     31'd16383,     31'd8191,      31'd4095,      31'd2047
    };

endpackage

>>> sv/ikslv_sqrt.sv
module ikslv_sqrt #(
    parameter int RAD_W = 52
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [RAD_W-1:0]       i_rad,
    output logic                   o_done,
    output logic [RAD_W/2-1:0]     o_root,
    output logic [RAD_W/2+2:0]     o_rem
);

    localparam int RES_W = RAD_W / 2;
    localparam int REM_W = RES_W + 3;
    localparam int CNT_W = $clog2(RES_W);

    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [RES_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] n_rem;
    logic [RES_W-1:0] n_root;
    logic             last;

    // one result bit per cycle, two radicand bits shifted in
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        if (rem_sh >= trial) begin
            n_rem  = rem_sh - trial;
            n_root = {r_root[RES_W-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh;
            n_root = {r_root[RES_W-2:0], 1'b0};
        end
        last = (r_cnt == CNT_W'(RES_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

>>> sv/ikslv_cordic.sv
module ikslv_cordic #(
    parameter int XW    = 34,
    parameter int STEPS = 14,
    parameter int AF    = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    output logic                          o_done,
    output logic signed [ikslv_pkg::Z_W-1:0] o_angle
);

    localparam int ZW = ikslv_pkg::Z_W;
    localparam int IW = ikslv_pkg::ATAN_IDX_W;

    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_i;
    logic                 r_busy;
    logic                 r_done;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] a;
    logic signed [ZW-1:0] zr;
    logic                 last;

    always_comb begin
        xs   = r_x >>> r_i;
        ys   = r_y >>> r_i;
        a    = signed'(ZW'(ikslv_pkg::ATAN_Q30[r_i]));
        last = (r_i == IW'(STEPS - 1));
        zr   = (r_z + signed'(ZW'(64'd1 << (29 - AF)))) >>> (30 - AF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // vectoring: drive y toward zero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= '0;
            r_i <= '0;
        end else if (r_busy) begin
            if (!r_y[XW-1]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + a;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - a;
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_done  = r_done;
    assign o_angle = zr;

endmodule

>>> sv/two_link_arm_ik_solver_core.sv
// Two-link inverse kinematics solver, equal links, fixed-point angles.
// Input channel (i_valid/o_ready) takes one target point per transaction;
// output channel (o_valid/i_ready) returns one result per target.
// Config channel (i_cfg_valid/o_cfg_ready, index + data) is always ready;
// write it only while the block is idle.
// Sequence: three squares on one multiplier, then up to three runs of a
// one-bit-per-cycle square root unit and up to two runs of a CORDIC unit.
// Targets at the base or beyond reach skip the later root/CORDIC runs.
// One target is in work at a time; o_ready is high only while idle.
// The result sits in an output register; a stalled receiver holds it and the
// next target may be accepted, but its result waits until the register frees.
// Synchronous reset returns config registers to their defaults and drops
// any target in work.
module two_link_arm_ik_solver_core #(
    parameter int COORD_WIDTH     = 10,
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int CORDIC_STEPS    = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [COORD_WIDTH-1:0] i_target_x,
    input  logic [COORD_WIDTH-1:0] i_target_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [14:0]            o_distance,
    output logic signed [13:0]     o_target_elevation,
    output logic [12:0]            o_half_angle,
    output logic signed [14:0]     o_shoulder_angle,
    output logic [13:0]            o_elbow_angle,
    output logic signed [15:0]     o_elbow_relative,
    output logic [13:0]            o_complement_angle,
    output logic                   o_shoulder_clamped,
    output logic                   o_elbow_clamped,
    output logic [1:0]             o_status,
    output logic                   o_left_of_base,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int AF    = ANGLE_FRAC_BITS;
    localparam int BW    = (CW < 10) ? CW : 10;
    localparam int MW    = (CW > 9) ? CW : 9;
    localparam int D2_W  = (2 * CW + 1 > 20) ? 2 * CW + 1 : 20;
    localparam int SQ_W  = ((D2_W + 31) / 2) * 2;
    localparam int RES_W = SQ_W / 2;
    localparam int XW    = (CW + 24 > RES_W + 4) ? CW + 24 : RES_W + 4;
    localparam int ZW    = ikslv_pkg::Z_W;

    localparam logic signed [19:0] PI_F =
        20'((ikslv_pkg::PI_Q30 + (64'd1 << (29 - AF))) >> (30 - AF));
    localparam logic signed [19:0] HPI_F =
        20'((ikslv_pkg::PI_Q30 + (64'd1 << (30 - AF))) >> (31 - AF));
    localparam logic [12:0] HPI_SAT = (HPI_F > 20'sd8191) ? 13'd8191 : 13'(HPI_F);

    ikslv_pkg::t_state r_state, n_state;

    logic [BW-1:0]       r_base_x, r_base_y;
    logic [8:0]          r_link;
    logic signed [14:0]  r_sh_max, r_sh_min;
    logic [13:0]         r_el_min;

    logic                r_go;
    logic signed [CW:0]  r_dy;
    logic [CW-1:0]       r_adx, r_ady;
    logic                r_left;
    logic [D2_W-1:0]     r_d2, r_reach2;
    logic [RES_W-1:0]    r_xs;
    logic [14:0]         r_dist;
    logic signed [13:0]  r_elev;
    logic [12:0]         r_half;
    logic [1:0]          r_status;
    logic signed [14:0]  r_sh;
    logic                r_sh_cl;
    logic [13:0]         r_el;
    logic                r_el_cl;

    logic                r_out_valid;
    logic [14:0]         r_o_dist;
    logic signed [13:0]  r_o_elev;
    logic [12:0]         r_o_half;
    logic signed [14:0]  r_o_sh;
    logic [13:0]         r_o_el;
    logic signed [15:0]  r_o_rel;
    logic [13:0]         r_o_comp;
    logic                r_o_sh_cl, r_o_el_cl, r_o_left;
    logic [1:0]          r_o_status;

    logic                accept;
    logic                unit_state;
    logic                sq_start, cd_start;
    logic [SQ_W-1:0]     sq_rad;
    logic                sq_done;
    logic [RES_W-1:0]    sq_root;
    logic [RES_W+2:0]    sq_rem;
    logic signed [XW-1:0] cd_x, cd_y;
    logic                cd_done;
    logic signed [ZW-1:0] cd_angle;

    logic [MW-1:0]       mul_a;
    logic [2*MW-1:0]     prod;
    logic signed [CW:0]  dx_in, dy_in;
    logic [RES_W:0]      dist_rnd;
    logic [D2_W-1:0]     reach_diff;
    logic signed [15:0]  sh_raw;
    logic signed [18:0]  el_raw;
    logic signed [18:0]  el_flr;
    logic signed [19:0]  rel_raw;
    logic signed [19:0]  comp_raw;
    logic                out_free;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == ikslv_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= BW'(160);
            r_base_y <= BW'(120);
            r_link   <= 9'd50;
            r_sh_max <= 15'sd12868;
            r_sh_min <= 15'sd0;
            r_el_min <= 14'd4289;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ikslv_pkg::CFG_BASE_X:       r_base_x <= i_cfg_data[BW-1:0];
                ikslv_pkg::CFG_BASE_Y:       r_base_y <= i_cfg_data[BW-1:0];
                ikslv_pkg::CFG_LINK_LENGTH:  r_link   <= i_cfg_data[8:0];
                ikslv_pkg::CFG_SHOULDER_MAX: r_sh_max <= signed'(i_cfg_data[14:0]);
                ikslv_pkg::CFG_SHOULDER_MIN: r_sh_min <= signed'(i_cfg_data[14:0]);
                ikslv_pkg::CFG_ELBOW_MIN:    r_el_min <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // shared multiplier and unit operands
    always_comb begin
        dx_in = signed'((CW+1)'(r_base_x)) - signed'({1'b0, i_target_x});
        dy_in = signed'((CW+1)'(r_base_y)) - signed'({1'b0, i_target_y});
        case (r_state)
            ikslv_pkg::S_SQX: mul_a = MW'(r_adx);
            ikslv_pkg::S_SQY: mul_a = MW'(r_ady);
            default:          mul_a = MW'(r_link);
        endcase
        prod       = mul_a * mul_a;
        reach_diff = r_reach2 - r_d2;
        case (r_state)
            ikslv_pkg::S_DIST: sq_rad = SQ_W'(r_d2) << 8;
            ikslv_pkg::S_XS:   sq_rad = SQ_W'(r_d2) << 30;
            default:           sq_rad = SQ_W'(reach_diff) << 30;
        endcase
        if (r_state == ikslv_pkg::S_ELEV) begin
            cd_x = XW'(signed'({1'b0, r_adx})) <<< 20;
            cd_y = XW'(r_dy) <<< 20;
        end else begin
            cd_x = signed'(XW'(r_xs));
            cd_y = signed'(XW'(sq_root));
        end
        dist_rnd = (RES_W+1)'(sq_root) + (RES_W+1)'((RES_W+3)'(sq_root) < sq_rem);
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        unit_state = 1'b0;
        sq_start   = 1'b0;
        cd_start   = 1'b0;
        unique case (r_state)
            ikslv_pkg::S_IDLE: if (i_valid) n_state = ikslv_pkg::S_SQX;
            ikslv_pkg::S_SQX:  n_state = ikslv_pkg::S_SQY;
            ikslv_pkg::S_SQY:  n_state = ikslv_pkg::S_SQL;
            ikslv_pkg::S_SQL:  n_state = ikslv_pkg::S_DIST;
            ikslv_pkg::S_DIST: begin
                unit_state = 1'b1;
                sq_start   = !r_go;
                if (sq_done) n_state = ikslv_pkg::S_ELEV;
            end
            ikslv_pkg::S_ELEV: begin
                if (r_d2 == '0) begin
                    n_state = ikslv_pkg::S_ANG;
                end else begin
                    unit_state = 1'b1;
                    cd_start   = !r_go;
                    if (cd_done) begin
                        n_state = (r_d2 > r_reach2) ? ikslv_pkg::S_ANG : ikslv_pkg::S_XS;
                    end
                end
            end
            ikslv_pkg::S_XS: begin
                unit_state = 1'b1;
                sq_start   = !r_go;
                if (sq_done) n_state = ikslv_pkg::S_YS;
            end
            ikslv_pkg::S_YS: begin
                unit_state = 1'b1;
                sq_start   = !r_go;
                if (sq_done) begin
                    n_state = (sq_root == '0) ? ikslv_pkg::S_ANG : ikslv_pkg::S_HALF;
                end
            end
            ikslv_pkg::S_HALF: begin
                unit_state = 1'b1;
                cd_start   = !r_go;
                if (cd_done) n_state = ikslv_pkg::S_ANG;
            end
            ikslv_pkg::S_ANG:  n_state = ikslv_pkg::S_FIN;
            ikslv_pkg::S_FIN:  if (out_free) n_state = ikslv_pkg::S_IDLE;
            default:           n_state = ikslv_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ikslv_pkg::S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sq_start || cd_start) begin
                r_go <= 1'b1;
            end else if (sq_done || cd_done || !unit_state) begin
                r_go <= 1'b0;
            end
            if (r_state == ikslv_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // angle stage
    always_comb begin
        sh_raw   = 16'(r_elev) + signed'({3'b000, r_half});
        el_raw   = 19'(PI_F) - signed'({5'b00000, r_half, 1'b0});
        el_flr   = el_raw[18] ? '0 : el_raw;
        rel_raw  = signed'({6'b000000, r_el}) - PI_F + 20'(r_sh);
        comp_raw = HPI_F - 20'(r_elev);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dy     <= dy_in;
            r_adx    <= dx_in[CW] ? CW'(-dx_in) : dx_in[CW-1:0];
            r_ady    <= dy_in[CW] ? CW'(-dy_in) : dy_in[CW-1:0];
            r_left   <= i_target_x < CW'(r_base_x);
            r_elev   <= '0;
            r_half   <= HPI_SAT;
            r_status <= ikslv_pkg::ST_AT_BASE;
        end
        case (r_state)
            ikslv_pkg::S_SQX: r_d2 <= D2_W'(prod);
            ikslv_pkg::S_SQY: r_d2 <= r_d2 + D2_W'(prod);
            ikslv_pkg::S_SQL: r_reach2 <= D2_W'(prod) << 2;
            ikslv_pkg::S_DIST: begin
                if (sq_done) begin
                    r_dist <= (dist_rnd > (RES_W+1)'(32767)) ? 15'd32767 : 15'(dist_rnd);
                end
            end
            ikslv_pkg::S_ELEV: begin
                if (cd_done) begin
                    if (cd_angle > ZW'(8191)) begin
                        r_elev <= 14'sd8191;
                    end else if (cd_angle < -ZW'(8192)) begin
                        r_elev <= -14'sd8192;
                    end else begin
                        r_elev <= 14'(cd_angle);
                    end
                    r_half   <= '0;
                    r_status <= (r_d2 > r_reach2) ? ikslv_pkg::ST_BEYOND
                                                  : ikslv_pkg::ST_REACHABLE;
                end
            end
            ikslv_pkg::S_XS: if (sq_done) r_xs <= sq_root;
            ikslv_pkg::S_HALF: begin
                if (cd_done) begin
                    if (cd_angle[ZW-1]) begin
                        r_half <= '0;
                    end else if (cd_angle > ZW'(8191)) begin
                        r_half <= 13'd8191;
                    end else begin
                        r_half <= 13'(cd_angle);
                    end
                end
            end
            ikslv_pkg::S_ANG: begin
                if (sh_raw > 16'(r_sh_max)) begin
                    r_sh    <= r_sh_max;
                    r_sh_cl <= 1'b1;
                end else if (sh_raw < 16'(r_sh_min)) begin
                    r_sh    <= r_sh_min;
                    r_sh_cl <= 1'b1;
                end else begin
                    r_sh    <= 15'(sh_raw);
                    r_sh_cl <= 1'b0;
                end
                // floor at zero first, then raise to the elbow minimum
                if (el_flr < signed'({5'b00000, r_el_min})) begin
                    r_el    <= r_el_min;
                    r_el_cl <= 1'b1;
                end else begin
                    r_el    <= (el_flr > 19'sd16383) ? 14'd16383 : 14'(el_flr);
                    r_el_cl <= 1'b0;
                end
            end
            ikslv_pkg::S_FIN: begin
                if (out_free) begin
                    r_o_dist   <= r_dist;
                    r_o_elev   <= r_elev;
                    r_o_half   <= r_half;
                    r_o_sh     <= r_sh;
                    r_o_el     <= r_el;
                    if (rel_raw > 20'sd32767) begin
                        r_o_rel <= 16'sh7FFF;
                    end else if (rel_raw < -20'sd32768) begin
                        r_o_rel <= -16'sd32768;
                    end else begin
                        r_o_rel <= 16'(rel_raw);
                    end
                    if (comp_raw[19]) begin
                        r_o_comp <= '0;
                    end else if (comp_raw > 20'sd16383) begin
                        r_o_comp <= 14'd16383;
                    end else begin
                        r_o_comp <= 14'(comp_raw);
                    end
                    r_o_sh_cl  <= r_sh_cl;
                    r_o_el_cl  <= r_el_cl;
                    r_o_status <= r_status;
                    r_o_left   <= r_left;
                end
            end
            default: ;
        endcase
    end

    ikslv_sqrt #(
        .RAD_W (SQ_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root),
        .o_rem   (sq_rem)
    );

    ikslv_cordic #(
        .XW    (XW),
        .STEPS (CORDIC_STEPS),
        .AF    (AF)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_x     (cd_x),
        .i_y     (cd_y),
        .o_done  (cd_done),
        .o_angle (cd_angle)
    );

    assign o_valid            = r_out_valid;
    assign o_distance         = r_o_dist;
    assign o_target_elevation = r_o_elev;
    assign o_half_angle       = r_o_half;
    assign o_shoulder_angle   = r_o_sh;
    assign o_elbow_angle      = r_o_el;
    assign o_elbow_relative   = r_o_rel;
    assign o_complement_angle = r_o_comp;
    assign o_shoulder_clamped = r_o_sh_cl;
    assign o_elbow_clamped    = r_o_el_cl;
    assign o_status           = r_o_status;
    assign o_left_of_base     = r_o_left;

endmodule

>>> tb/tb.sv
module tb;

    localparam int  RAND_PER_PHASE = 270;
    localparam int  N_PHASES       = 6;
    localparam int  CALM_TAIL      = 150;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [14:0] distance;
        logic [13:0] elevation;
        logic [12:0] half;
        logic [14:0] shoulder;
        logic [13:0] elbow;
        logic [15:0] elbow_rel;
        logic [13:0] complement;
        logic        sh_clamped;
        logic        el_clamped;
        logic [1:0]  status;
        logic        left;
    } t_ik_sol;

    typedef struct {
        logic [9:0] tx;
        logic [9:0] ty;
        bit         typed;       // status and distance typed in below
        logic [1:0] status;
        logic [14:0] distance;
    } t_target_row;

    typedef struct {
        logic [9:0]  bx;
        logic [9:0]  by;
        logic [8:0]  link;
        logic [14:0] smax;
        logic [14:0] smin;
        logic [13:0] emin;
    } t_arm_cfg;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [9:0]  i_target_x;
    logic [9:0]  i_target_y;
    logic        o_valid;
    logic        i_ready;
    logic [14:0] o_distance;
    logic signed [13:0] o_target_elevation;
    logic [12:0] o_half_angle;
    logic signed [14:0] o_shoulder_angle;
    logic [13:0] o_elbow_angle;
    logic signed [15:0] o_elbow_relative;
    logic [13:0] o_complement_angle;
    logic        o_shoulder_clamped;
    logic        o_elbow_clamped;
    logic [1:0]  o_status;
    logic        o_left_of_base;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    two_link_arm_ik_solver_core dut (.*);

    // shadow copy of the arm registers
    longint base_x, base_y, link_len, sh_max, sh_min, el_min;

    t_ik_sol     pending_sols[$];
    t_target_row row_typed[$];
    int          mismatches;
    int          solved;
    int          beyond_seen;
    int          at_base_seen;
    bit          calm;
    longint      cycles;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring CORDIC, x >= 0; result in 2^-12 rad, rounded
    function automatic longint vec_atan2(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        for (int i = 0; i < 14; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += longint'(ikslv_pkg::ATAN_Q30[i]);
            end else begin
                x = x - ys; y = y + xs; z -= longint'(ikslv_pkg::ATAN_Q30[i]);
            end
        end
        return (z + (64'sd1 << 17)) >>> 18;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_ik_sol solve_arm(logic [9:0] tx, logic [9:0] ty);
        t_ik_sol s;
        longint pi_f, hpi_f, dx, dy, adx, d2, reach2, r, dist_q;
        longint elev, half, sh, el, xs, ys;
        logic [1:0] st;
        pi_f   = (longint'(ikslv_pkg::PI_Q30) + (64'sd1 << 17)) >> 18;
        hpi_f  = (longint'(ikslv_pkg::PI_Q30) + (64'sd1 << 18)) >> 19;
        dx     = base_x - longint'(tx);
        dy     = base_y - longint'(ty);
        adx    = dx < 0 ? -dx : dx;
        d2     = dx * dx + dy * dy;
        reach2 = 4 * link_len * link_len;
        s      = '0;
        r      = d2 * 256;
        dist_q = int_sqrt(r);
        if (r - dist_q * dist_q > dist_q) dist_q++;
        if (dist_q > 32767) dist_q = 32767;
        if (d2 == 0) begin
            st = ikslv_pkg::ST_AT_BASE; elev = 0; half = hpi_f;
        end else begin
            elev = vec_atan2(dy << 20, adx << 20);
            if (d2 > reach2) begin
                st = ikslv_pkg::ST_BEYOND; half = 0;
            end else begin
                xs = int_sqrt(d2 << 30);
                ys = int_sqrt((reach2 - d2) << 30);
                st = ikslv_pkg::ST_REACHABLE;
                half = ys == 0 ? 0 : vec_atan2(ys, xs);
                if (half < 0) half = 0;
            end
        end
        elev = clip(elev, -8192, 8191);
        half = clip(half, 0, 8191);
        sh = elev + half;
        if (sh > sh_max) begin
            sh = sh_max; s.sh_clamped = 1'b1;
        end else if (sh < sh_min) begin
            sh = sh_min; s.sh_clamped = 1'b1;
        end
        el = pi_f - 2 * half;
        if (el < 0) el = 0;
        if (el < el_min) begin
            el = el_min; s.el_clamped = 1'b1;
        end
        el = clip(el, 0, 16383);
        s.distance   = dist_q[14:0];
        s.elevation  = elev[13:0];
        s.half       = half[12:0];
        s.shoulder   = sh[14:0];
        s.elbow      = el[13:0];
        s.elbow_rel  = 16'(clip(el - (pi_f - sh), -32768, 32767));
        s.complement = 14'(clip(hpi_f - elev, 0, 16383));
        s.status     = st;
        s.left       = longint'(tx) < base_x;
        return s;
    endfunction

    function automatic void note_field(string name, longint e, longint a);
        if (e != a) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d (result %0d)",
                         name, e, a, solved);
        end
    endfunction

    // result side
    always @(posedge i_clk) begin
        t_ik_sol e;
        t_target_row t;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_sols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: result with nothing pending");
            end else begin
                e = pending_sols.pop_front();
                t = row_typed.pop_front();
                if (t.typed) begin
                    note_field("status (typed)", t.status, o_status);
                    note_field("distance (typed)", t.distance, o_distance);
                end
                note_field("distance", e.distance, o_distance);
                note_field("elevation", e.elevation, o_target_elevation[13:0]);
                note_field("half_angle", e.half, o_half_angle);
                note_field("shoulder", e.shoulder, o_shoulder_angle[14:0]);
                note_field("elbow", e.elbow, o_elbow_angle);
                note_field("elbow_rel", e.elbow_rel, o_elbow_relative[15:0]);
                note_field("complement", e.complement, o_complement_angle);
                note_field("sh_clamped", e.sh_clamped, o_shoulder_clamped);
                note_field("el_clamped", e.el_clamped, o_elbow_clamped);
                note_field("status", e.status, o_status);
                note_field("left_of_base", e.left, o_left_of_base);
                if (e.status == ikslv_pkg::ST_BEYOND) beyond_seen++;
                if (e.status == ikslv_pkg::ST_AT_BASE) at_base_seen++;
            end
            solved++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL two_link_arm_ik_solver_core");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ikslv_pkg::CFG_BASE_X:       base_x   = data[9:0];
            ikslv_pkg::CFG_BASE_Y:       base_y   = data[9:0];
            ikslv_pkg::CFG_LINK_LENGTH:  link_len = data[8:0];
            ikslv_pkg::CFG_SHOULDER_MAX: sh_max   = longint'(signed'(data[14:0]));
            ikslv_pkg::CFG_SHOULDER_MIN: sh_min   = longint'(signed'(data[14:0]));
            ikslv_pkg::CFG_ELBOW_MIN:    el_min   = data[13:0];
            default: ;
        endcase
    endtask

    // one target transaction; valid held until accepted
    task automatic send_target(t_target_row t);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_target_x <= t.tx;
        i_target_y <= t.ty;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_sols.push_back(solve_arm(t.tx, t.ty));
        row_typed.push_back(t);
    endtask

    function automatic logic [9:0] near_coord(longint c, longint span);
        longint v;
        v = c + longint'($urandom_range(0, 2 * span)) - span;
        return 10'(clip(v, 0, 1023));
    endfunction

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sols.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    initial begin
        t_target_row rows[$];
        t_target_row t;
        t_arm_cfg    phases[N_PHASES];
        int          total, sent, pick;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_target_x  = '0;
        i_target_y  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ikslv_pkg::CFG_BASE_X;
        i_cfg_data  = '0;
        mismatches  = 0;
        solved      = 0;
        beyond_seen = 0;
        at_base_seen = 0;
        calm        = 1'b0;
        cycles      = 0;
        base_x = 160; base_y = 120; link_len = 50;
        sh_max = 12868; sh_min = 0; el_min = 4289;

        phases[0] = '{10'd160, 10'd120, 9'd50, 15'd12868, 15'd0, 14'd4289};
        phases[1] = '{10'd512, 10'd512, 9'd511, 15'h3FFF, 15'h4000, 14'd0};
        // shoulder_min above shoulder_max
        phases[2] = '{10'd0, 10'd0, 9'd1, 15'h4000, 15'h3FFF, 14'h3FFF};
        phases[3] = '{10'd1023, 10'd1023, 9'd300, 15'd8000, -15'sd3000, 14'd1000};
        phases[4] = '{10'd300, 10'd700, 9'd100, 15'd5000, 15'd2000, 14'd6000};
        phases[5] = '{10'd160, 10'd120, 9'd50, 15'd12868, 15'd0, 14'd4289};

        // directed targets, at reset settings (base 160,120, links 50)
        rows = '{
            '{10'd160, 10'd120, 1, ikslv_pkg::ST_AT_BASE,   15'd0},
            '{10'd260, 10'd120, 1, ikslv_pkg::ST_REACHABLE, 15'd1600},
            '{10'd60,  10'd120, 1, ikslv_pkg::ST_REACHABLE, 15'd1600},
            '{10'd160, 10'd20,  1, ikslv_pkg::ST_REACHABLE, 15'd1600},
            '{10'd160, 10'd220, 1, ikslv_pkg::ST_REACHABLE, 15'd1600},
            '{10'd261, 10'd120, 1, ikslv_pkg::ST_BEYOND,    15'd1616},
            '{10'd0,   10'd0,   0, ikslv_pkg::ST_BEYOND, '0},
            '{10'd1023, 10'd1023, 0, ikslv_pkg::ST_BEYOND, '0},
            '{10'd0,   10'd1023, 0, ikslv_pkg::ST_BEYOND, '0},
            '{10'd1023, 10'd0,   0, ikslv_pkg::ST_BEYOND, '0},
            '{10'd161, 10'd120, 0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd159, 10'd121, 0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd160, 10'd119, 0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd210, 10'd120, 0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd200, 10'd150, 0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd120, 10'd90,  0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd130, 10'd200, 0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd90,  10'd50,  0, ikslv_pkg::ST_REACHABLE, '0},
            '{10'd341, 10'd682, 0, ikslv_pkg::ST_BEYOND, '0},
            '{10'd682, 10'd341, 0, ikslv_pkg::ST_BEYOND, '0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_target(rows[k]);
        settle();

        total = N_PHASES * RAND_PER_PHASE;
        sent  = 0;
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(ikslv_pkg::CFG_BASE_X, {6'd0, phases[p].bx});
            write_reg(ikslv_pkg::CFG_BASE_Y, {6'd0, phases[p].by});
            write_reg(ikslv_pkg::CFG_LINK_LENGTH, {7'd0, phases[p].link});
            write_reg(ikslv_pkg::CFG_SHOULDER_MAX, {1'b0, phases[p].smax});
            write_reg(ikslv_pkg::CFG_SHOULDER_MIN, {1'b0, phases[p].smin});
            write_reg(ikslv_pkg::CFG_ELBOW_MIN, {2'd0, phases[p].emin});
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (sent >= total - CALM_TAIL) calm = 1'b1;
                t = '{10'd0, 10'd0, 0, ikslv_pkg::ST_REACHABLE, '0};
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    t.tx = near_coord(base_x, 2 * link_len + 2);
                    t.ty = near_coord(base_y, 2 * link_len + 2);
                end else if (pick < 78) begin
                    t.tx = base_x[9:0];
                    t.ty = base_y[9:0];
                end else begin
                    t.tx = 10'($urandom_range(0, 1023));
                    t.ty = 10'($urandom_range(0, 1023));
                end
                send_target(t);
                sent++;
            end
            settle();
        end

        $display("%0d targets solved over %0d arm settings plus directed checks;",
                 solved, N_PHASES);
        $display("%0d beyond reach, %0d at the base", beyond_seen, at_base_seen);
        if (mismatches == 0 && pending_sols.size() == 0) begin
            $display("PASS two_link_arm_ik_solver_core");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     mismatches, pending_sols.size());
            $display("FAIL two_link_arm_ik_solver_core");
        end
        $finish;
    end

endmodule

>>> files.f
sv/ikslv_pkg.sv
sv/ikslv_sqrt.sv
sv/ikslv_cordic.sv
sv/two_link_arm_ik_solver_core.sv
tb/tb.sv
